FILE: hdl/tcw_pkg.sv
package tcw_pkg;

    localparam int CMD_W  = 3;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;
    localparam int DATA_W = 32;
    localparam int UPC_W  = 5;

    localparam logic [CMD_W-1:0] CMD_PUT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd10;
    localparam logic              REG_ATTR   = 1'b0;

    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [1:0] {
        ADDR_CURSOR  = 2'd0,
        ADDR_PTR     = 2'd1,
        ADDR_PTR_ROW = 2'd2,
        ADDR_POS     = 2'd3
    } t_addr_sel;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_CHAR  = 2'd1,
        WR_BLANK = 2'd2,
        WR_COPY  = 2'd3
    } t_wr_sel;

    typedef enum logic [1:0] {
        PTR_NONE     = 2'd0,
        PTR_ZERO     = 2'd1,
        PTR_LAST_ROW = 2'd2,
        PTR_INC      = 2'd3
    } t_ptr_op;

    typedef enum logic [2:0] {
        CUR_NONE      = 3'd0,
        CUR_INC       = 3'd1,
        CUR_LF        = 3'd2,
        CUR_DEC       = 3'd3,
        CUR_UP        = 3'd4,
        CUR_LOAD      = 3'd5,
        CUR_BASE_STEP = 3'd6
    } t_cur_op;

    typedef enum logic [3:0] {
        COND_NEVER      = 4'd0,
        COND_ALWAYS     = 4'd1,
        COND_IS_CR      = 4'd2,
        COND_IS_LF      = 4'd3,
        COND_CUR_IN     = 4'd4,
        COND_CUR_ZERO   = 4'd5,
        COND_POS_OOR    = 4'd6,
        COND_BASE_FOUND = 4'd7,
        COND_PTR_MORE   = 4'd8,
        COND_COPY_MORE  = 4'd9
    } t_cond;

    typedef struct packed {
        t_addr_sel addr;
        t_wr_sel   wr;
        t_ptr_op   ptr;
        t_cur_op   cur;
        logic      cap;
        logic      set_scr;
        t_cond     cond;
        t_upc      target;
        logic      done;
    } t_uword;

    typedef struct packed {
        t_uword uw;
        logic   start;
    } t_ctrl;

    typedef struct packed {
        logic is_cr;
        logic is_lf;
        logic cur_in;
        logic cur_zero;
        logic pos_oor;
        logic base_found;
        logic ptr_more;
        logic copy_more;
    } t_flags;

    localparam t_upc U_IDLE     = 5'd0;
    localparam t_upc U_PUT      = 5'd1;
    localparam t_upc U_PUT_LF_Q = 5'd2;
    localparam t_upc U_PUT_WR   = 5'd3;
    localparam t_upc U_PUT_LF   = 5'd4;
    localparam t_upc U_CHK      = 5'd5;
    localparam t_upc U_SCR_INIT = 5'd6;
    localparam t_upc U_CP_RD    = 5'd7;
    localparam t_upc U_CP_WR    = 5'd8;
    localparam t_upc U_BL_INIT  = 5'd9;
    localparam t_upc U_BL_LOOP  = 5'd10;
    localparam t_upc U_FIN      = 5'd11;
    localparam t_upc U_BS       = 5'd12;
    localparam t_upc U_BS_DEC   = 5'd13;
    localparam t_upc U_BS_WR    = 5'd14;
    localparam t_upc U_CLR      = 5'd15;
    localparam t_upc U_CLR_LOOP = 5'd16;
    localparam t_upc U_CLR_END  = 5'd17;
    localparam t_upc U_SET      = 5'd18;
    localparam t_upc U_SET_CHK  = 5'd19;
    localparam t_upc U_SET_STEP = 5'd20;
    localparam t_upc U_RD       = 5'd21;
    localparam t_upc U_RD_ADDR  = 5'd22;
    localparam t_upc U_RD_CAP   = 5'd23;

    localparam t_uword UW_NOP = '{
        addr: ADDR_CURSOR, wr: WR_NONE, ptr: PTR_NONE, cur: CUR_NONE,
        cap: 1'b0, set_scr: 1'b0, cond: COND_NEVER, target: U_IDLE, done: 1'b0
    };

    function automatic t_upc f_entry(input logic [CMD_W-1:0] cmd);
        t_upc e;
        unique case (cmd)
            CMD_PUT:   e = U_PUT;
            CMD_BACK:  e = U_BS;
            CMD_CLEAR: e = U_CLR;
            CMD_SET:   e = U_SET;
            CMD_READ:  e = U_RD;
            default:   e = U_FIN;
        endcase
        return e;
    endfunction

    function automatic t_uword f_ucode(input t_upc a);
        t_uword w;
        w = UW_NOP;
        unique case (a)
            U_PUT: begin
                w.cond = COND_IS_CR; w.target = U_FIN;
            end
            U_PUT_LF_Q: begin
                w.cond = COND_IS_LF; w.target = U_PUT_LF;
            end
            U_PUT_WR: begin
                w.addr = ADDR_CURSOR; w.wr = WR_CHAR; w.cur = CUR_INC;
                w.cond = COND_ALWAYS; w.target = U_CHK;
            end
            U_PUT_LF: begin
                w.cur = CUR_LF;
            end
            U_CHK: begin
                w.cond = COND_CUR_IN; w.target = U_FIN;
            end
            U_SCR_INIT: begin
                w.ptr = PTR_ZERO; w.set_scr = 1'b1;
            end
            U_CP_RD: begin
                w.addr = ADDR_PTR_ROW;
            end
            U_CP_WR: begin
                w.addr = ADDR_PTR; w.wr = WR_COPY; w.ptr = PTR_INC;
                w.cond = COND_COPY_MORE; w.target = U_CP_RD;
            end
            U_BL_INIT: begin
                w.ptr = PTR_LAST_ROW; w.cur = CUR_UP;
            end
            U_BL_LOOP: begin
                w.addr = ADDR_PTR; w.wr = WR_BLANK; w.ptr = PTR_INC;
                w.cond = COND_PTR_MORE; w.target = U_BL_LOOP;
            end
            U_FIN: begin
                w.done = 1'b1;
            end
            U_BS: begin
                w.cond = COND_CUR_ZERO; w.target = U_FIN;
            end
            U_BS_DEC: begin
                w.cur = CUR_DEC;
            end
            U_BS_WR: begin
                w.addr = ADDR_CURSOR; w.wr = WR_BLANK;
                w.cond = COND_ALWAYS; w.target = U_FIN;
            end
            U_CLR: begin
                w.ptr = PTR_ZERO;
            end
            U_CLR_LOOP: begin
                w.addr = ADDR_PTR; w.wr = WR_BLANK; w.ptr = PTR_INC;
                w.cond = COND_PTR_MORE; w.target = U_CLR_LOOP;
            end
            U_CLR_END: begin
                w.cond = COND_ALWAYS; w.target = U_FIN;
            end
            U_SET: begin
                w.cur = CUR_LOAD;
            end
            U_SET_CHK: begin
                w.cond = COND_BASE_FOUND; w.target = U_FIN;
            end
            U_SET_STEP: begin
                w.cur = CUR_BASE_STEP;
                w.cond = COND_ALWAYS; w.target = U_SET_CHK;
            end
            U_RD: begin
                w.cond = COND_POS_OOR; w.target = U_FIN;
            end
            U_RD_ADDR: begin
                w.addr = ADDR_POS;
            end
            U_RD_CAP: begin
                w.cap = 1'b1;
                w.cond = COND_ALWAYS; w.target = U_FIN;
            end
            default: w = UW_NOP;
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/tcw_screen_ram.sv
module tcw_screen_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [CELL_W-1:0]        i_wdata,
    output logic [CELL_W-1:0]        o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tcw_datapath.sv
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    input  logic [ATTR_W-1:0] i_attr,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [POS_W-1:0]  i_position,
    output t_flags            o_flags,
    output logic [POS_W-1:0]  o_cursor_pos,
    output logic [CELL_W-1:0] o_cell_value,
    output logic              o_scrolled
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int PW    = (CW > POS_W) ? CW : POS_W;

    t_uword uw;

    logic [CW-1:0]     r_cursor, n_cursor;
    logic [CW-1:0]     r_base, n_base;
    logic [AW-1:0]     r_ptr;
    logic [CELL_W-1:0] r_cell;
    logic              r_scr;
    logic [CHAR_W-1:0] r_char;
    logic [POS_W-1:0]  r_pos;

    logic [CW-1:0]     cursor_inc;
    logic [CW-1:0]     base_nr;
    logic [PW-1:0]     pos_ext;
    logic              pos_oor;
    logic [CW-1:0]     pos_sat;
    logic [AW-1:0]     ram_addr;
    logic              ram_we;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;

    assign uw         = i_ctrl.uw;
    assign cursor_inc = r_cursor + CW'(1);
    assign base_nr    = r_base + CW'(COLUMNS);
    assign pos_ext    = PW'(r_pos);
    assign pos_oor    = pos_ext >= PW'(CELLS);
    assign pos_sat    = pos_oor ? CW'(CELLS - 1) : CW'(pos_ext);

    always_comb begin
        n_cursor = r_cursor;
        n_base   = r_base;
        unique case (uw.cur)
            CUR_NONE: ;
            CUR_INC: begin
                n_cursor = cursor_inc;
                if (cursor_inc == base_nr) begin
                    n_base = base_nr;
                end
            end
            CUR_LF: begin
                n_cursor = base_nr;
                n_base   = base_nr;
            end
            CUR_DEC: begin
                n_cursor = r_cursor - CW'(1);
                if (r_cursor == r_base) begin
                    n_base = r_base - CW'(COLUMNS);
                end
            end
            CUR_UP: begin
                n_cursor = r_cursor - CW'(COLUMNS);
                n_base   = r_base - CW'(COLUMNS);
            end
            CUR_LOAD: begin
                n_cursor = pos_sat;
                n_base   = '0;
            end
            CUR_BASE_STEP: n_base = base_nr;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_base   <= '0;
        end else begin
            r_cursor <= n_cursor;
            r_base   <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (uw.ptr)
            PTR_NONE:     ;
            PTR_ZERO:     r_ptr <= '0;
            PTR_LAST_ROW: r_ptr <= AW'(CELLS - COLUMNS);
            PTR_INC:      r_ptr <= r_ptr + AW'(1);
        endcase
        if (i_ctrl.start) begin
            r_char <= i_char_code;
            r_pos  <= i_position;
            r_cell <= '0;
            r_scr  <= 1'b0;
        end else begin
            if (uw.cap) begin
                r_cell <= ram_rdata;
            end
            if (uw.set_scr) begin
                r_scr <= 1'b1;
            end
        end
    end

    always_comb begin
        unique case (uw.addr)
            ADDR_CURSOR:  ram_addr = AW'(r_cursor);
            ADDR_PTR:     ram_addr = r_ptr;
            ADDR_PTR_ROW: ram_addr = AW'(CW'(r_ptr) + CW'(COLUMNS));
            ADDR_POS:     ram_addr = AW'(pos_ext);
        endcase
    end

    always_comb begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        unique case (uw.wr)
            WR_NONE:  ram_we = 1'b0;
            WR_CHAR:  ram_wdata = {i_attr, r_char};
            WR_BLANK: ram_wdata = {i_attr, CH_SPACE};
            WR_COPY:  ram_wdata = ram_rdata;
        endcase
    end

    tcw_screen_ram #(
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_flags.is_cr      = r_char == CH_CR;
    assign o_flags.is_lf      = r_char == CH_LF;
    assign o_flags.cur_in     = r_cursor < CW'(CELLS);
    assign o_flags.cur_zero   = r_cursor == '0;
    assign o_flags.pos_oor    = pos_oor;
    assign o_flags.base_found = r_cursor < base_nr;
    assign o_flags.ptr_more   = r_ptr != AW'(CELLS - 1);
    assign o_flags.copy_more  = r_ptr != AW'(CELLS - COLUMNS - 1);

    assign o_cursor_pos = POS_W'(r_cursor);
    assign o_cell_value = r_cell;
    assign o_scrolled   = r_scr;

endmodule

FILE: hdl/tcw_sequencer.sv
module tcw_sequencer
    import tcw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic             i_out_free,
    input  t_flags           i_flags,
    output t_ctrl            o_ctrl,
    output logic             o_busy,
    output logic             o_load_out
);

    t_upc   r_upc, n_upc;
    t_uword uw;
    logic   cond_true;
    logic   idle;

    assign uw   = f_ucode(r_upc);
    assign idle = r_upc == U_IDLE;

    always_comb begin
        unique case (uw.cond)
            COND_NEVER:      cond_true = 1'b0;
            COND_ALWAYS:     cond_true = 1'b1;
            COND_IS_CR:      cond_true = i_flags.is_cr;
            COND_IS_LF:      cond_true = i_flags.is_lf;
            COND_CUR_IN:     cond_true = i_flags.cur_in;
            COND_CUR_ZERO:   cond_true = i_flags.cur_zero;
            COND_POS_OOR:    cond_true = i_flags.pos_oor;
            COND_BASE_FOUND: cond_true = i_flags.base_found;
            COND_PTR_MORE:   cond_true = i_flags.ptr_more;
            COND_COPY_MORE:  cond_true = i_flags.copy_more;
            default:         cond_true = 1'b0;
        endcase
    end

    always_comb begin
        priority if (idle) begin
            n_upc = i_in_valid ? f_entry(i_cmd) : U_IDLE;
        end else if (uw.done) begin
            n_upc = i_out_free ? U_IDLE : r_upc;
        end else if (cond_true) begin
            n_upc = uw.target;
        end else begin
            n_upc = t_upc'(r_upc + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl.uw    = uw;
    assign o_ctrl.start = idle && i_in_valid;
    assign o_busy       = !idle;
    assign o_load_out   = uw.done && i_out_free;

endmodule

FILE: hdl/text_console_writer_unit.sv
// Text console of COLUMNS x ROWS cells (attribute byte over character byte) with a cursor,
// run by a microcoded sequencer over a single-port screen store. The input side takes one
// command at a time and stalls until its result is in the output register. A carriage
// return, a backspace at cell 0, an out-of-range read and an unused command finish early;
// set cursor steps a row base from row 0 up to the target row. Clear screen sweeps the
// store at one cell a cycle. A scroll copies each cell through the store's one port, a
// read and then a write, and then blanks the last row. A stalled result holds the
// sequencer in its final step until the output register is free.
// The store powers up undefined; clear it before reading cells that were never written.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [POS_W-1:0]  i_position,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [POS_W-1:0]  o_cursor_pos,
    output logic [CELL_W-1:0] o_cell_value,
    output logic              o_scrolled,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_ctrl             ctrl;
    t_flags            flags;
    logic              busy;
    logic              load_out;
    logic              out_free;
    logic [POS_W-1:0]  dp_cursor;
    logic [CELL_W-1:0] dp_cell;
    logic              dp_scr;

    logic [ATTR_W-1:0] r_attr;
    logic              r_out_valid;
    logic [POS_W-1:0]  r_cursor_pos;
    logic [CELL_W-1:0] r_cell_value;
    logic              r_scrolled;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ATTR) ? DATA_W'(r_attr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ATTR) begin
            r_attr <= pwdata[ATTR_W-1:0];
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    tcw_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_ctrl     (ctrl),
        .o_busy     (busy),
        .o_load_out (load_out)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_attr       (r_attr),
        .i_char_code  (i_char_code),
        .i_position   (i_position),
        .o_flags      (flags),
        .o_cursor_pos (dp_cursor),
        .o_cell_value (dp_cell),
        .o_scrolled   (dp_scr)
    );

    // hold the result until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_cursor_pos <= dp_cursor;
            r_cell_value <= dp_cell;
            r_scrolled   <= dp_scr;
        end
    end

    assign o_in_stall   = busy;
    assign o_out_valid  = r_out_valid;
    assign o_cursor_pos = r_cursor_pos;
    assign o_cell_value = r_cell_value;
    assign o_scrolled   = r_scrolled;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb
    import tcw_pkg::*;
();

    localparam int SCR_COLS  = 80;
    localparam int SCR_ROWS  = 25;
    localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;
    localparam int POS_TOP   = (1 << POS_W) - 1;

    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_READ + 3'd1;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;
    localparam logic [2:0]       ATTR_ADDR       = {REG_ATTR, 2'b00};

    typedef struct packed {
        logic [POS_W-1:0]  cur_pos;
        logic [CELL_W-1:0] cell_val;
        logic              scr;
    } t_echo;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [CMD_W-1:0]  i_cmd       = CMD_PUT;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic [POS_W-1:0]  i_position  = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [POS_W-1:0]  o_cursor_pos;
    logic [CELL_W-1:0] o_cell_value;
    logic              o_scrolled;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [2:0]        paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic [CELL_W-1:0] shadow_cells [SCR_CELLS];
    int                shadow_cursor = 0;
    logic [ATTR_W-1:0] shadow_attr   = ATTR_RESET;
    t_echo             awaited_echoes [$];

    bit steady    = 1'b0;
    int hold_left = 0;
    int n_faults  = 0;
    int n_sent    = 0;
    int n_scrolls = 0;
    int n_wipes   = 0;
    int n_attrs   = 0;

    text_console_writer_unit #(
        .COLUMNS(SCR_COLS),
        .ROWS   (SCR_ROWS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_char_code (i_char_code),
        .i_position  (i_position),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cursor_pos(o_cursor_pos),
        .o_cell_value(o_cell_value),
        .o_scrolled  (o_scrolled),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("[text_console_writer_unit] ERROR");
        $finish;
    end

    function automatic t_echo console_apply(input logic [CMD_W-1:0] cmd,
                                            input logic [CHAR_W-1:0] ch,
                                            input logic [POS_W-1:0] pos);
        t_echo r;
        r = '0;
        case (cmd)
            CMD_PUT: begin
                if (ch != CH_CR) begin
                    if (ch == CH_LF) begin
                        shadow_cursor = (shadow_cursor / SCR_COLS + 1) * SCR_COLS;
                    end else begin
                        shadow_cells[shadow_cursor] = {shadow_attr, ch};
                        shadow_cursor++;
                    end
                    if (shadow_cursor >= SCR_CELLS) begin
                        for (int i = 0; i < SCR_CELLS - SCR_COLS; i++)
                            shadow_cells[i] = shadow_cells[i + SCR_COLS];
                        for (int i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++)
                            shadow_cells[i] = {shadow_attr, CH_SPACE};
                        shadow_cursor -= SCR_COLS;
                        r.scr = 1'b1;
                        n_scrolls++;
                    end
                end
            end
            CMD_BACK: begin
                if (shadow_cursor > 0) begin
                    shadow_cursor--;
                    shadow_cells[shadow_cursor] = {shadow_attr, CH_SPACE};
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < SCR_CELLS; i++)
                    shadow_cells[i] = {shadow_attr, CH_SPACE};
                n_wipes++;
            end
            CMD_SET: begin
                shadow_cursor = (pos < SCR_CELLS) ? int'(pos) : SCR_CELLS - 1;
            end
            CMD_READ: begin
                if (pos < SCR_CELLS)
                    r.cell_val = shadow_cells[pos];
            end
            default: ;
        endcase
        r.cur_pos = shadow_cursor[POS_W-1:0];
        return r;
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                            input logic [POS_W-1:0] pos);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_char_code <= ch;
        i_position  <= pos;
        do @(posedge i_clk); while (o_in_stall);
        awaited_echoes.push_back(console_apply(cmd, ch, pos));
        n_sent++;
    endtask

    task automatic await_drain(input int settle);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_echoes.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_attribute(input logic [ATTR_W-1:0] attr);
        await_drain(4);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ATTR_ADDR;
        pwdata  <= {{(DATA_W-ATTR_W){1'b0}}, attr};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_attr = attr;
        n_attrs++;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(DATA_W-ATTR_W){1'b0}}, attr}) begin
            $display("%0t: attribute readback expected %h actual %h", $time, attr, prdata);
            n_faults++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic roll_item(input bit noise, output logic [CMD_W-1:0] cmd,
                             output logic [CHAR_W-1:0] ch, output logic [POS_W-1:0] pos);
        int          r;
        logic [31:0] rnd;
        r   = $urandom_range(0, 99);
        rnd = $urandom_range(8'h20, 8'h7e);
        cmd = CMD_PUT;
        ch  = rnd[CHAR_W-1:0];
        rnd = $urandom_range(0, POS_TOP);
        pos = rnd[POS_W-1:0];
        if (noise) begin
            rnd = $urandom;
            cmd = rnd[CMD_W-1:0];
            ch  = rnd[CMD_W+CHAR_W-1:CMD_W];
            if (cmd == CMD_CLEAR && r >= 10)
                cmd = CMD_READ;
        end else if (r < 8) begin
            ch = CH_LF;
        end else if (r < 11) begin
            ch = CH_CR;
        end else if (r < 14) begin
            rnd = $urandom;
            ch  = rnd[CHAR_W-1:0];
        end else if (r < 19) begin
            cmd = CMD_BACK;
        end else if (r < 27) begin
            cmd = CMD_SET;
            if (r < 23) begin
                rnd = $urandom_range(SCR_CELLS - 2 * SCR_COLS, POS_TOP);
                pos = rnd[POS_W-1:0];
            end
        end else if (r < 39) begin
            cmd = CMD_READ;
        end else if (r == 39) begin
            cmd = CMD_CLEAR;
        end
    endtask

    task automatic send_random(input int n, input bit noise);
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
        repeat (n) begin
            roll_item(noise, cmd, ch, pos);
            send_cmd(cmd, ch, pos);
        end
    endtask

    task automatic test_reset_state();
        send_cmd(CMD_READ, 8'h00, 11'd2047);
        send_cmd(CMD_READ, 8'hff, 11'd2000);
        send_cmd(CMD_SPARE_FIRST, 8'h55, 11'd0);
        send_cmd(CMD_SPARE_LAST, 8'haa, 11'd1999);
        send_cmd(CMD_CLEAR, 8'h00, 11'd0);
    endtask

    task automatic test_put_and_edit();
        send_cmd(CMD_PUT, 8'h41, 11'd0);
        send_cmd(CMD_PUT, CH_CR, 11'd0);
        send_cmd(CMD_PUT, CH_LF, 11'd0);
        send_cmd(CMD_PUT, 8'h00, 11'd0);
        send_cmd(CMD_PUT, 8'hff, 11'd0);
        send_cmd(CMD_BACK, 8'h00, 11'd0);
        send_cmd(CMD_SET, 8'h00, 11'd0);
        send_cmd(CMD_BACK, 8'h00, 11'd0);
        send_cmd(CMD_READ, 8'h00, 11'd0);
        send_cmd(CMD_READ, 8'h00, 11'd80);
        send_cmd(CMD_SET, 8'h00, 11'd2047);
        send_cmd(CMD_PUT, 8'h5a, 11'd0);
        send_cmd(CMD_READ, 8'h00, 11'd1919);
        send_cmd(CMD_SET, 8'h00, 11'd1920);
        send_cmd(CMD_PUT, CH_LF, 11'd0);
        send_cmd(CMD_READ, 8'h00, 11'd0);
    endtask

    task automatic test_text_stream();
        steady = 1'b1;
        send_random(250, 1'b0);
        steady = 1'b0;
        send_random(450, 1'b0);
    endtask

    task automatic test_attributes();
        logic [31:0] rnd;
        rnd = $urandom;
        set_attribute(8'h00);
        send_cmd(CMD_CLEAR, 8'h00, 11'd0);
        send_random(30, 1'b0);
        set_attribute(8'hff);
        send_cmd(CMD_SET, 8'h00, 11'd1990);
        send_random(30, 1'b0);
        set_attribute(rnd[ATTR_W-1:0]);
        send_cmd(CMD_CLEAR, 8'h00, 11'd0);
        send_random(30, 1'b0);
        set_attribute(ATTR_RESET);
    endtask

    task automatic test_receiver_hold();
        @(posedge i_clk);
        hold_left = 300;
        send_random(30, 1'b0);
    endtask

    task automatic test_sender_pause();
        send_random(20, 1'b0);
        await_drain(0);
        send_random(20, 1'b1);
    endtask

    task automatic test_noise();
        send_random(650, 1'b1);
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= !steady && ($urandom_range(0, 99) < 15);
        end
    end

    always @(posedge i_clk) begin : check_echo
        t_echo want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_echoes.size() == 0) begin
                $display("%0t: unexpected transfer: cursor %0d cell %h scrolled %b",
                         $time, o_cursor_pos, o_cell_value, o_scrolled);
                n_faults++;
            end else begin
                want = awaited_echoes.pop_front();
                if (o_cursor_pos !== want.cur_pos) begin
                    $display("%0t: cursor expected %0d actual %0d",
                             $time, want.cur_pos, o_cursor_pos);
                    n_faults++;
                end
                if (o_cell_value !== want.cell_val) begin
                    $display("%0t: cell expected %h actual %h",
                             $time, want.cell_val, o_cell_value);
                    n_faults++;
                end
                if (o_scrolled !== want.scr) begin
                    $display("%0t: scrolled expected %b actual %b",
                             $time, want.scr, o_scrolled);
                    n_faults++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_put_and_edit();
        test_text_stream();
        test_attributes();
        test_receiver_hold();
        test_sender_pause();
        test_noise();
        await_drain(40);
        $display("Run covered %0d commands: %0d scrolls, %0d screen clears,", n_sent,
                 n_scrolls, n_wipes);
        $display("%0d attribute settings, receiver hold and sender pause.", n_attrs);
        if (n_faults == 0) begin
            $display("[text_console_writer_unit] OK");
        end else begin
            $display("[text_console_writer_unit] ERROR");
        end
        $finish;
    end

endmodule

FILE: text_console_writer_unit.f
hdl/tcw_pkg.sv
hdl/tcw_screen_ram.sv
hdl/tcw_datapath.sv
hdl/tcw_sequencer.sv
hdl/text_console_writer_unit.sv
test/tb.sv
